[hdl/spq_pkg.sv]
// Package for the sorted priority job queue: sizes, codes, slot and result types.
// Used by spq_if, spq_seq and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  // Queue geometry
  localparam int QueueDepth  = 16;
  localparam int PayloadBits = 32;
  localparam int AddrW       = $clog2(QueueDepth);
  localparam int CountW      = $clog2(QueueDepth + 1);

  // Fixed field widths of the channels
  localparam int PrioW = 16;
  localparam int TagW  = 32;
  localparam int OccW  = 5;
  localparam int StatW = 2;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    STAT_PUSHED = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_POPPED = 2'd2,
    STAT_EMPTY  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PLACE,
    S_POP,
    S_DONE
  } state_e;

  // One stored job
  typedef struct packed {
    logic [PrioW-1:0]       prio;
    logic [PayloadBits-1:0] payload;
  } slot_t;

  localparam int SlotW = $bits(slot_t);

  // One finished result
  typedef struct packed {
    status_e          status;
    logic [PrioW-1:0] prio;
    logic [TagW-1:0]  payload;
    logic [OccW-1:0]  occupancy;
  } res_t;

  // Request to the slot memory
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    slot_t            wdata;
    logic [AddrW-1:0] raddr;
  } ram_req_t;

  // Physical slot of logical position off in the ring starting at head
  function automatic logic [AddrW-1:0] slot_addr(input logic [AddrW-1:0] head,
                                                 input logic [CountW-1:0] off);
    logic [CountW:0] sum;
    sum = (CountW + 1)'(head) + (CountW + 1)'(off);
    if (sum >= (CountW + 1)'(QueueDepth)) begin
      sum = sum - (CountW + 1)'(QueueDepth);
    end
    return AddrW'(sum);
  endfunction

endpackage

`default_nettype wire

[hdl/spq_if.sv]
// Channel interfaces of the sorted priority job queue: command in, result out.
// Depends on spq_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface spq_in_if;
  logic                             valid;
  logic                             ready;
  logic                             cmd;
  logic signed [spq_pkg::PrioW-1:0] job_priority;
  logic [spq_pkg::TagW-1:0]         job_payload;

  modport source (output valid, cmd, job_priority, job_payload, input ready);
  modport sink   (input valid, cmd, job_priority, job_payload, output ready);
endinterface

interface spq_out_if;
  logic                             valid;
  logic                             ready;
  logic [spq_pkg::StatW-1:0]        status;
  logic signed [spq_pkg::PrioW-1:0] out_priority;
  logic [spq_pkg::TagW-1:0]         out_payload;
  logic [spq_pkg::OccW-1:0]         occupancy;

  modport source (output valid, status, out_priority, out_payload, occupancy, input ready);
  modport sink   (input valid, status, out_priority, out_payload, occupancy, output ready);
endinterface

`default_nettype wire

[hdl/sorted_priority_job_queue.sv]
// Top level of the sorted priority job queue: slot memory, sequencer, result register.
// Depends on spq_pkg, spq_if, spq_ram and spq_seq.
//
// Use: in_chan carries commands (push a job with priority and payload tag, or pop
// the head job); out_chan returns one result transaction per command: status,
// popped priority and payload (zero unless popped) and the occupancy afterwards.
// Jobs are held in a ring in one RAM, sorted with the lowest priority at the head;
// a push goes in front of any job of equal priority.
// A rejected command forms its result at once; a pop first reads the head slot,
// as the RAM read is registered. A push walks from the tail towards its place, one
// slot per cycle, moving each job of equal or higher priority one slot back.
// One command is in work at a time; in_chan.ready rises again once its result has
// moved to the output register, so a new command is taken while that result waits.
// Reset (rst_n low, synchronous) empties the queue; slot contents are not cleared.
// A stalled receiver holds the result; the next one stays in the sequencer.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_job_queue (
  input wire logic clk,
  input wire logic rst_n,
  spq_in_if.sink   in_chan,
  spq_out_if.source out_chan
);

  spq_pkg::ram_req_t ram_req;
  spq_pkg::slot_t    ram_rdata;
  spq_pkg::res_t     res;
  logic              res_valid;
  logic              res_take;
  logic              out_valid_r;
  spq_pkg::res_t     out_res_r;

  // slot memory
  spq_ram #(
    .Depth (spq_pkg::QueueDepth),
    .Width (spq_pkg::SlotW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // command sequencer
  spq_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata),
    .res       (res),
    .res_valid (res_valid),
    .res_take  (res_take)
  );

  // output register
  assign res_take = res_valid && (!out_valid_r || out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_res_r <= res;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = out_res_r.status;
  assign out_chan.out_priority = out_res_r.prio;
  assign out_chan.out_payload  = out_res_r.payload;
  assign out_chan.occupancy    = out_res_r.occupancy;

endmodule

`default_nettype wire

[hdl/spq_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No package dependency.
`timescale 1ns / 1ps
`default_nettype none

module spq_ram #(
  parameter int Depth = 16,
  parameter int Width = 48
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output      logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hdl/spq_seq.sv]
// Sequencer of the sorted priority job queue: ring head and count, sorted-insert
// scan and pop over the slot memory. Depends on spq_pkg and spq_if.
`timescale 1ns / 1ps
`default_nettype none

module spq_seq (
  input  wire logic              clk,
  input  wire logic              rst_n,
  spq_in_if.sink                 in_chan,
  output      spq_pkg::ram_req_t ram_req,
  input  wire spq_pkg::slot_t    ram_rdata,
  output      spq_pkg::res_t     res,
  output      logic              res_valid,
  input  wire logic              res_take
);

  spq_pkg::state_e                 state_r, state_nxt;
  logic [spq_pkg::AddrW-1:0]       head_r, head_nxt;
  logic [spq_pkg::CountW-1:0]      count_r, count_nxt;
  logic [spq_pkg::CountW-1:0]      k_r, k_nxt;    // logical slot being vacated
  spq_pkg::slot_t                  job_r, job_nxt;
  spq_pkg::res_t                   res_r, res_nxt;
  logic [spq_pkg::CountW-1:0]      count_inc, count_dec;

  assign count_inc = count_r + 1'b1;
  assign count_dec = count_r - 1'b1;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= spq_pkg::S_IDLE;
      head_r  <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    k_r   <= k_nxt;
    job_r <= job_nxt;
    res_r <= res_nxt;
  end

  // next state, memory requests
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    k_nxt         = k_r;
    job_nxt       = job_r;
    res_nxt       = res_r;
    ram_req       = '0;
    ram_req.raddr = spq_pkg::slot_addr(head_r, k_r - 2'd2);
    in_chan.ready = 1'b0;
    res_valid     = 1'b0;

    case (state_r)
      spq_pkg::S_IDLE: begin
        in_chan.ready = 1'b1;
        if (in_chan.valid) begin
          job_nxt.prio    = in_chan.job_priority;
          job_nxt.payload = spq_pkg::PayloadBits'(in_chan.job_payload);
          res_nxt         = '0;
          res_nxt.occupancy = spq_pkg::OccW'(count_r);
          if (in_chan.cmd == spq_pkg::CMD_PUSH) begin
            if (count_r >= spq_pkg::CountW'(spq_pkg::QueueDepth)) begin
              res_nxt.status = spq_pkg::STAT_FULL;
              state_nxt      = spq_pkg::S_DONE;
            end else begin
              // scan from the tail towards the head
              k_nxt         = count_r;
              ram_req.raddr = spq_pkg::slot_addr(head_r, count_dec);
              state_nxt     = (count_r == '0) ? spq_pkg::S_PLACE : spq_pkg::S_SCAN;
            end
          end else begin
            if (count_r == '0) begin
              res_nxt.status = spq_pkg::STAT_EMPTY;
              state_nxt      = spq_pkg::S_DONE;
            end else begin
              ram_req.raddr = head_r;
              state_nxt     = spq_pkg::S_POP;
            end
          end
        end
      end

      spq_pkg::S_SCAN: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = spq_pkg::slot_addr(head_r, k_r);
        if ($signed(ram_rdata.prio) >= $signed(job_r.prio)) begin
          // move the stored job one place back, fetch the next one
          ram_req.wdata = ram_rdata;
          k_nxt         = k_r - 1'b1;
          state_nxt     = (k_r == spq_pkg::CountW'(1)) ? spq_pkg::S_PLACE : spq_pkg::S_SCAN;
        end else begin
          ram_req.wdata     = job_r;
          count_nxt         = count_inc;
          res_nxt.status    = spq_pkg::STAT_PUSHED;
          res_nxt.occupancy = spq_pkg::OccW'(count_inc);
          state_nxt         = spq_pkg::S_DONE;
        end
      end

      spq_pkg::S_PLACE: begin
        ram_req.we        = 1'b1;
        ram_req.waddr     = spq_pkg::slot_addr(head_r, k_r);
        ram_req.wdata     = job_r;
        count_nxt         = count_inc;
        res_nxt.status    = spq_pkg::STAT_PUSHED;
        res_nxt.occupancy = spq_pkg::OccW'(count_inc);
        state_nxt         = spq_pkg::S_DONE;
      end

      spq_pkg::S_POP: begin
        res_nxt.status    = spq_pkg::STAT_POPPED;
        res_nxt.prio      = ram_rdata.prio;
        res_nxt.payload   = spq_pkg::TagW'(ram_rdata.payload);
        res_nxt.occupancy = spq_pkg::OccW'(count_dec);
        head_nxt          = spq_pkg::slot_addr(head_r, spq_pkg::CountW'(1));
        count_nxt         = count_dec;
        state_nxt         = spq_pkg::S_DONE;
      end

      spq_pkg::S_DONE: begin
        res_valid = 1'b1;
        if (res_take) begin
          state_nxt = spq_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = spq_pkg::S_IDLE;
      end
    endcase
  end

  assign res = res_r;

endmodule

`default_nettype wire
